// ----- rtl/sdc_pkg.sv -----
package sdc_pkg;

    // Default sizes of the block
    localparam int SDC_VALUE_BITS  = 17;
    localparam int SDC_PRIME_COUNT = 72;

    // Result and factor widths, fixed by the result field
    localparam int COUNT_W  = 12;
    localparam int EXP_W    = 5;
    localparam int FACT_W   = EXP_W + 1;
    localparam int MUL_W    = COUNT_W + FACT_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
    localparam logic [FACT_W-1:0]  PRIME_POWER_FACTOR = 6'd3;

    // Quotient bits retired per divider cycle
    localparam int DIV_BITS = 4;

    // Microcode addressing
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] PC_FETCH  = 4'd1;
    localparam logic [PC_W-1:0] PC_SQUARE = 4'd2;
    localparam logic [PC_W-1:0] PC_TEST   = 4'd3;
    localparam logic [PC_W-1:0] PC_DIV    = 4'd4;
    localparam logic [PC_W-1:0] PC_DSTEP  = 4'd5;
    localparam logic [PC_W-1:0] PC_EXACT  = 4'd6;
    localparam logic [PC_W-1:0] PC_TAKE   = 4'd7;
    localparam logic [PC_W-1:0] PC_FACT   = 4'd8;
    localparam logic [PC_W-1:0] PC_NEXT   = 4'd9;
    localparam logic [PC_W-1:0] PC_TAIL   = 4'd10;
    localparam logic [PC_W-1:0] PC_DONE   = 4'd11;

    // Datapath actions
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_FETCH    = 4'd2,
        OP_SQUARE   = 4'd3,
        OP_DIV_INIT = 4'd4,
        OP_DIV_STEP = 4'd5,
        OP_TAKE     = 4'd6,
        OP_MUL      = 4'd7,
        OP_NEXT     = 4'd8,
        OP_MUL3     = 4'd9,
        OP_DONE     = 4'd10
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NO_START   = 3'd2,
        C_SQ_GT      = 3'd3,
        C_DIV_BUSY   = 3'd4,
        C_NOT_EXACT  = 3'd5,
        C_LAST_PRIME = 3'd6
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Divider control and status
    typedef struct packed {
        logic init;
        logic step;
    } div_ctrl_t;

    typedef struct packed {
        logic last;
        logic exact;
    } div_stat_t;

    // Control store: run the op, then jump to target when cond holds
    function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
        uword_t w;
        begin
            case (pc)
                PC_IDLE:   w = '{op: OP_LOAD,     cond: C_NO_START,   target: PC_IDLE};
                PC_FETCH:  w = '{op: OP_FETCH,    cond: C_NEVER,      target: PC_IDLE};
                PC_SQUARE: w = '{op: OP_SQUARE,   cond: C_NEVER,      target: PC_IDLE};
                PC_TEST:   w = '{op: OP_NONE,     cond: C_SQ_GT,      target: PC_TAIL};
                PC_DIV:    w = '{op: OP_DIV_INIT, cond: C_NEVER,      target: PC_IDLE};
                PC_DSTEP:  w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,   target: PC_DSTEP};
                PC_EXACT:  w = '{op: OP_NONE,     cond: C_NOT_EXACT,  target: PC_FACT};
                PC_TAKE:   w = '{op: OP_TAKE,     cond: C_ALWAYS,     target: PC_DIV};
                PC_FACT:   w = '{op: OP_MUL,      cond: C_LAST_PRIME, target: PC_TAIL};
                PC_NEXT:   w = '{op: OP_NEXT,     cond: C_ALWAYS,     target: PC_FETCH};
                PC_TAIL:   w = '{op: OP_MUL3,     cond: C_NEVER,      target: PC_IDLE};
                PC_DONE:   w = '{op: OP_DONE,     cond: C_ALWAYS,     target: PC_IDLE};
                default:   w = '{op: OP_NONE,     cond: C_ALWAYS,     target: PC_IDLE};
            endcase
            return w;
        end
    endfunction

    // Prime of index n (from zero), evaluated at elaboration only
    function automatic int nth_prime(input int n);
        int count;
        int cand;
        int k;
        int m;
        bit is_p;
        begin
            count = 0;
            cand  = 1;
            while (count <= n) begin
                cand = cand + 1;
                is_p = 1'b1;
                k    = 2;
                while (is_p && (k * k <= cand)) begin
                    m = k * k;
                    while (m < cand) begin
                        m = m + k;
                    end
                    if (m == cand) begin
                        is_p = 1'b0;
                    end
                    k = k + 1;
                end
                if (is_p) begin
                    count = count + 1;
                end
            end
            return cand;
        end
    endfunction

endpackage

// ----- rtl/sdc_divider.sv -----
module sdc_divider
    import sdc_pkg::*;
#(
    parameter int VALUE_BITS = SDC_VALUE_BITS,
    parameter int PRIME_W    = 9
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [PRIME_W-1:0]    divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output div_stat_t             stat
);

    localparam int DIV_CYC = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W   = DIV_CYC * DIV_BITS;
    localparam int CNT_W   = $clog2(DIV_CYC);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYC - 1);

    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W-1:0]   quo_next;
    logic [PRIME_W-1:0] part_reg;
    logic [PRIME_W-1:0] part_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [DIV_W-1:0]   q_work;
    logic [PRIME_W:0]   p_work;

    // Retire DIV_BITS quotient bits by restoring shift and subtract
    always_comb
    begin
        q_work = quo_reg;
        p_work = {1'b0, part_reg};
        for (int i = 0; i < DIV_BITS; i++)
        begin
            p_work = {p_work[PRIME_W-1:0], q_work[DIV_W-1]};
            q_work = {q_work[DIV_W-2:0], 1'b0};
            if (p_work >= {1'b0, divisor})
            begin
                p_work    = p_work - {1'b0, divisor};
                q_work[0] = 1'b1;
            end
        end
    end

    // Load, advance or hold the working registers
    always_comb
    begin
        quo_next  = quo_reg;
        part_next = part_reg;
        cnt_next  = cnt_reg;
        if (ctrl.init)
        begin
            quo_next  = DIV_W'(dividend);
            part_next = '0;
            cnt_next  = '0;
        end
        else if (ctrl.step)
        begin
            quo_next  = q_work;
            part_next = p_work[PRIME_W-1:0];
            cnt_next  = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
    end

    assign quotient   = quo_reg[VALUE_BITS-1:0];
    assign stat.last  = (cnt_reg == CNT_LAST);
    assign stat.exact = (part_reg == '0);

    // Step counter never runs past the last digit
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("divider step counter out of range");

endmodule

// ----- rtl/square_divisor_counter.sv -----
// Returns d(value*value), the divisor count of the square of value, by trial
// division over a built-in table of the first PRIME_COUNT primes. A transaction
// is taken when start is high and busy is low; busy then stays high until the
// result is out. The result appears on divisor_count for exactly one cycle with
// done high, and must be captured in that cycle: there is no back-pressure. A
// zero value returns 0. A new start may be given in the same cycle as done.
// The time to a result is set by the prime walk in the microcode sequencer and
// the shared iterative divider, which retires 4 quotient bits per cycle while
// it steps. Each prime tried costs a fetch, a squaring, a compare, a full
// division and a multiply into the count, plus another division and a take
// step for each time the prime divides out. The walk stops once the square of
// the prime exceeds what is left of the value, or after the 72 table primes.
module square_divisor_counter
    import sdc_pkg::*;
#(
    parameter int VALUE_BITS  = SDC_VALUE_BITS,
    parameter int PRIME_COUNT = SDC_PRIME_COUNT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  done,
    output logic [COUNT_W-1:0]    divisor_count
);

    localparam int IDX_W     = $clog2(PRIME_COUNT);
    localparam int PRIME_MAX = nth_prime(PRIME_COUNT - 1);
    localparam int PRIME_W   = $clog2(PRIME_MAX + 1);
    localparam int SQ_W      = 2 * PRIME_W;
    localparam int CMP_W     = (SQ_W > VALUE_BITS) ? SQ_W : VALUE_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PRIME_COUNT - 1);

    // Prime table, built at elaboration
    logic [PRIME_W-1:0] prime_rom [PRIME_COUNT];

    for (genvar g = 0; g < PRIME_COUNT; g++)
    begin : g_prime
        localparam int P = nth_prime(g);
        assign prime_rom[g] = PRIME_W'(P);
    end

    logic [PC_W-1:0]       pc_reg;
    logic [PC_W-1:0]       pc_next;
    uword_t                uw;
    logic                  jump;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic [EXP_W-1:0]      exp_reg;
    logic [EXP_W-1:0]      exp_next;
    logic [COUNT_W-1:0]    prod_reg;
    logic [COUNT_W-1:0]    prod_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [PRIME_W-1:0]    prime_reg;
    logic [PRIME_W-1:0]    prime_next;
    logic [SQ_W-1:0]       sq_reg;
    logic [SQ_W-1:0]       sq_next;
    logic                  done_reg;
    logic                  done_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  sq_gt;
    logic [FACT_W-1:0]     factor;
    logic [MUL_W-1:0]      mul_full;
    logic [COUNT_W-1:0]    mul_sat;
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [VALUE_BITS-1:0] div_quo;

    // Fetch the control word for this step
    assign uw    = ucode_word(pc_reg);
    assign sq_gt = CMP_W'(sq_reg) > CMP_W'(rem_reg);

    // Evaluate the jump condition
    always_comb
    begin
        case (uw.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_START:   jump = !start;
            C_SQ_GT:      jump = sq_gt;
            C_DIV_BUSY:   jump = !div_stat.last;
            C_NOT_EXACT:  jump = !div_stat.exact;
            C_LAST_PRIME: jump = (idx_reg == IDX_LAST);
            default:      jump = 1'b1;
        endcase
    end

    assign pc_next = jump ? uw.target : pc_reg + 1'b1;

    // Saturating multiply of the running count
    assign factor   = (uw.op == OP_MUL3) ? PRIME_POWER_FACTOR : {exp_reg, 1'b1};
    assign mul_full = MUL_W'(prod_reg) * MUL_W'(factor);
    assign mul_sat  = (mul_full > MUL_W'(COUNT_MAX)) ? COUNT_MAX : mul_full[COUNT_W-1:0];

    // Divider hookup
    assign div_ctrl.init = (uw.op == OP_DIV_INIT);
    assign div_ctrl.step = (uw.op == OP_DIV_STEP);

    sdc_divider #(
        .VALUE_BITS (VALUE_BITS),
        .PRIME_W    (PRIME_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (rem_reg),
        .divisor  (prime_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Datapath actions
    always_comb
    begin
        rem_next   = rem_reg;
        exp_next   = exp_reg;
        prod_next  = prod_reg;
        idx_next   = idx_reg;
        prime_next = prime_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        case (uw.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    rem_next  = value;
                    exp_next  = '0;
                    prod_next = (value == '0) ? '0 : COUNT_W'(1);
                    idx_next  = '0;
                end
            end
            OP_FETCH:  prime_next = prime_rom[idx_reg];
            OP_SQUARE: sq_next = SQ_W'(prime_reg) * SQ_W'(prime_reg);
            OP_TAKE:
            begin
                rem_next = div_quo;
                exp_next = exp_reg + 1'b1;
            end
            OP_MUL:
            begin
                prod_next = mul_sat;
                exp_next  = '0;
            end
            OP_NEXT:   idx_next = idx_reg + 1'b1;
            OP_MUL3:
            begin
                if (rem_reg > VALUE_BITS'(1))
                begin
                    prod_next = mul_sat;
                end
            end
            OP_DONE:
            begin
                done_next  = 1'b1;
                count_next = prod_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        exp_reg   <= exp_next;
        prod_reg  <= prod_next;
        idx_reg   <= idx_next;
        prime_reg <= prime_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
    end

    assign busy          = (pc_reg != PC_IDLE);
    assign done          = done_reg;
    assign divisor_count = count_reg;

    // A result strobe follows the output step of the program
    a_done_from_program: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pc_reg == PC_DONE))
        else $error("result strobe without output step");

    // An accepted transaction makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    // A square always has an odd divisor count; zero flags a zero input
    a_count_odd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (divisor_count[0] || (divisor_count == '0)))
        else $error("even divisor count reported");

endmodule

// ----- tb/testbench.sv -----
module testbench
    import sdc_pkg::*;
();

    localparam int          VW           = SDC_VALUE_BITS;
    localparam int unsigned VALUE_TOP    = (1 << VW) - 1;
    localparam int          ITEM_TARGET  = 1350;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          TAIL_CYCLES  = 50;
    localparam int          DRAIN_EVERY  = 300;
    localparam int          CORNER_COUNT = 18;

    // Factoring corners: zero, unit, smooth and highly composite values,
    // squares and products of the largest table primes, alternating bit patterns
    localparam logic [VW-1:0] CORNER_VALUES [CORNER_COUNT] = '{
        17'd0,      17'd1,      17'd2,      17'd3,      17'd4,      17'd131071,
        17'd65536,  17'd120120, 17'd110880, 17'd128881, 17'd130321, 17'd126727,
        17'd359,    17'd98304,  17'd87381,  17'd43690,  17'd131070, 17'd0
    };

    typedef struct {
        logic [VW-1:0]      value;
        logic [COUNT_W-1:0] count;
    } count_entry_t;

    // Expected divisor counts of squares, in order of accepted transactions
    class divisor_scoreboard;
        int unsigned  prime_list [SDC_PRIME_COUNT];
        count_entry_t pending_counts [$];
        int           errors;
        int           checked;

        function new();
            int unsigned found;
            int unsigned cand;
            bit          composite;
            found   = 0;
            cand    = 2;
            errors  = 0;
            checked = 0;
            // Build the table of the first primes by trial division
            while (found < SDC_PRIME_COUNT)
            begin
                composite = 1'b0;
                for (int k = 0; k < found && prime_list[k] * prime_list[k] <= cand; k++)
                begin
                    if (cand % prime_list[k] == 0)
                    begin
                        composite = 1'b1;
                        break;
                    end
                end
                if (!composite)
                begin
                    prime_list[found] = cand;
                    found++;
                end
                cand++;
            end
        endfunction

        // Divisor count of value squared: product of (2e+1) over prime powers
        function logic [COUNT_W-1:0] square_divisor_count(logic [VW-1:0] value);
            int unsigned rest;
            int unsigned expo;
            int unsigned prod;
            int unsigned q;
            rest = 32'(value);
            prod = 1;
            if (rest == 0)
                return '0;
            for (int i = 0; i < SDC_PRIME_COUNT; i++)
            begin
                q = prime_list[i];
                if (q * q > rest)
                    break;
                if (rest % q == 0)
                begin
                    expo = 0;
                    while (rest % q == 0)
                    begin
                        rest = rest / q;
                        expo = (expo + 1) & 31;
                    end
                    prod = prod * (2 * expo + 1);
                    if (prod > COUNT_MAX)
                        prod = COUNT_MAX;
                end
            end
            // Leftover cofactor is a single prime to the first power
            if (rest > 1)
            begin
                prod = prod * PRIME_POWER_FACTOR;
                if (prod > COUNT_MAX)
                    prod = COUNT_MAX;
            end
            return prod[COUNT_W-1:0];
        endfunction

        function void note_value(logic [VW-1:0] value);
            count_entry_t entry;
            entry.value = value;
            entry.count = square_divisor_count(value);
            pending_counts = {pending_counts, entry};
        endfunction

        function void check_count(logic [COUNT_W-1:0] count);
            count_entry_t entry;
            if (pending_counts.size() == 0)
            begin
                $error("divisor_count %0d arrived with no transaction outstanding", count);
                errors++;
                return;
            end
            entry = pending_counts.pop_front();
            checked++;
            if (count !== entry.count)
            begin
                $error("divisor_count mismatch for value %0d: expected %0d, actual %0d",
                       entry.value, entry.count, count);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_counts.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VW-1:0]      value = '0;
    logic               busy;
    logic               done;
    logic [COUNT_W-1:0] divisor_count;

    divisor_scoreboard sb = new();
    int                stall_cycles = 0;
    int                sent = 0;
    int                zero_sent = 0;
    int                drains = 0;

    square_divisor_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .value         (value),
        .busy          (busy),
        .done          (done),
        .divisor_count (divisor_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watch both sides: check results, record accepted values, guard against hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_count(divisor_count);
            if (start && !busy)
                sb.note_value(value);
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.outstanding());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Hold start with the value until the block takes it
    task automatic push_value(input logic [VW-1:0] v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (v == 0)
            zero_sent++;
    endtask

    // Drop start for a number of cycles; zero keeps the stream back to back
    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop start and wait until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        drains++;
    endtask

    initial
    begin
        int          burst_left;
        int          kind;
        int unsigned acc;
        int unsigned q;
        logic [VW-1:0] v;

        // Hold reset, then release on a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, back to back with one gap in the middle
        for (int i = 0; i < CORNER_COUNT; i++)
        begin
            push_value(CORNER_VALUES[i]);
            if (i == CORNER_COUNT / 2)
                idle_gap(3);
        end
        drain_results();

        // Random mix in bursts
        burst_left = $urandom_range(1, 16);
        for (int n = 0; n < ITEM_TARGET; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                // Any value of the field
                v = VW'($urandom);
            end
            else if (kind < 40)
            begin
                // Edges of the range
                case ($urandom_range(0, 2))
                    0:       v = '0;
                    1:       v = VW'(1);
                    default: v = VW'(VALUE_TOP);
                endcase
            end
            else if (kind < 70)
            begin
                // Short factoring walks
                v = VW'($urandom_range(1, 2047));
            end
            else if (kind < 90)
            begin
                // Smooth numbers with repeated small factors
                acc = 1;
                repeat ($urandom_range(1, 12))
                begin
                    q = sb.prime_list[$urandom_range(0, 9)];
                    if (acc * q <= VALUE_TOP)
                        acc = acc * q;
                end
                v = VW'(acc);
            end
            else
            begin
                // Powers of a table prime, reaching out to the last entries
                q   = sb.prime_list[$urandom_range(0, SDC_PRIME_COUNT - 1)];
                acc = q;
                while (acc * q <= VALUE_TOP && $urandom_range(0, 2) != 0)
                    acc = acc * q;
                v = VW'(acc);
            end

            push_value(v);

            // Every so often let the block run dry before going on
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();

            burst_left--;
            if (burst_left == 0)
            begin
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
                burst_left = $urandom_range(1, 16);
            end
        end

        // Wait for the last results, then a short tail
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d values (%0d zero, %0d directed), checked %0d divisor counts,",
                 sent, zero_sent, CORNER_COUNT, sb.checked);
        $display("with %0d full drains; %0d mismatches", drains, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sdc_pkg.sv
rtl/sdc_divider.sv
rtl/square_divisor_counter.sv
tb/testbench.sv
